[rtl/core/ubxfr_pkg.sv]
package ubxfr_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    localparam logic [7:0]  RST_WANT_CLASS    = 8'd6;
    localparam logic [7:0]  RST_WANT_ID       = 8'd8;
    localparam logic [15:0] RST_PAYLOAD_LIMIT = 16'd256;
    localparam logic [15:0] RST_TIMEOUT_MS    = 16'd800;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WANT_CLASS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WANT_ID       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS    = 2'd3;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [1:0] ST_PAYLOAD = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    typedef enum logic [2:0] {
        PH_SYNC1   = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_CLASS   = 3'd2,
        PH_ID      = 3'd3,
        PH_LEN_LO  = 3'd4,
        PH_LEN_HI  = 3'd5,
        PH_PAYLOAD = 3'd6
    } t_phase;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  payload_byte;
        logic        last;
        logic [15:0] length;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  want_class;
        logic [7:0]  want_id;
        logic [15:0] payload_limit;
        logic [15:0] timeout_ms;
    } t_cfg;

    typedef struct packed {
        logic      has_result;
        t_out_item item;
    } t_step_res;

endpackage

[rtl/core/ubxfr_in_if.sv]
interface ubxfr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink   (input valid, input opcode, input rx_byte, output ready);
    modport mon    (input valid, input ready, input opcode, input rx_byte);
endinterface

[rtl/core/ubxfr_out_if.sv]
interface ubxfr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  payload_byte;
    logic        last;
    logic [15:0] length;

    modport source (output valid, output status, output payload_byte, output last,
                    output length, input ready);
    modport sink   (input valid, input status, input payload_byte, input last,
                    input length, output ready);
    modport mon    (input valid, input ready, input status, input payload_byte,
                    input last, input length);
endinterface

[rtl/core/ubxfr_core.sv]
module ubxfr_core
    import ubxfr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_step_res o_res
);

    logic        r_armed, n_armed;
    t_phase      r_phase, n_phase;
    logic [15:0] r_frame_len, n_frame_len;
    logic [15:0] r_left, n_left;
    logic [15:0] r_elapsed, n_elapsed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed     <= 1'b0;
            r_phase     <= PH_SYNC1;
            r_frame_len <= '0;
            r_left      <= '0;
            r_elapsed   <= '0;
        end else begin
            r_armed     <= n_armed;
            r_phase     <= n_phase;
            r_frame_len <= n_frame_len;
            r_left      <= n_left;
            r_elapsed   <= n_elapsed;
        end
    end

    always_comb begin
        logic [15:0] len_full;
        logic [15:0] elapsed_inc;

        len_full    = {i_item.rx_byte, r_frame_len[7:0]};
        elapsed_inc = (r_elapsed == 16'hFFFF) ? r_elapsed : r_elapsed + 16'd1;

        n_armed     = r_armed;
        n_phase     = r_phase;
        n_frame_len = r_frame_len;
        n_left      = r_left;
        n_elapsed   = r_elapsed;
        o_res       = '0;

        if (i_fire) begin
            unique case (i_item.opcode)
                OP_START: begin
                    n_armed     = 1'b1;
                    n_phase     = PH_SYNC1;
                    n_frame_len = '0;
                    n_left      = '0;
                    n_elapsed   = '0;
                end
                OP_BYTE: begin
                    if (r_armed) begin
                        unique case (r_phase)
                            PH_SYNC1: begin
                                if (i_item.rx_byte == SYNC_FIRST) n_phase = PH_SYNC2;
                            end
                            PH_SYNC2: begin
                                n_phase = (i_item.rx_byte == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
                            end
                            PH_CLASS: begin
                                n_phase = (i_item.rx_byte == i_cfg.want_class) ? PH_ID
                                                                               : PH_SYNC1;
                            end
                            PH_ID: begin
                                n_phase = (i_item.rx_byte == i_cfg.want_id) ? PH_LEN_LO
                                                                            : PH_SYNC1;
                            end
                            PH_LEN_LO: begin
                                n_frame_len = {8'd0, i_item.rx_byte};
                                n_phase     = PH_LEN_HI;
                            end
                            PH_LEN_HI: begin
                                n_frame_len = len_full;
                                if (len_full >= i_cfg.payload_limit) begin
                                    // at or above the payload limit: hunt again
                                    n_phase = PH_SYNC1;
                                end else if (len_full == 16'd0) begin
                                    n_armed                   = 1'b0;
                                    n_phase                   = PH_SYNC1;
                                    o_res.has_result          = 1'b1;
                                    o_res.item.status         = ST_EMPTY;
                                    o_res.item.last           = 1'b1;
                                end else begin
                                    n_left  = len_full;
                                    n_phase = PH_PAYLOAD;
                                end
                            end
                            PH_PAYLOAD: begin
                                o_res.has_result        = 1'b1;
                                o_res.item.status       = ST_PAYLOAD;
                                o_res.item.payload_byte = i_item.rx_byte;
                                if (r_left <= 16'd1) begin
                                    n_left            = '0;
                                    n_armed           = 1'b0;
                                    n_phase           = PH_SYNC1;
                                    o_res.item.last   = 1'b1;
                                    o_res.item.length = r_frame_len;
                                end else begin
                                    n_left = r_left - 16'd1;
                                end
                            end
                            default: n_phase = PH_SYNC1;
                        endcase
                    end
                end
                OP_TICK: begin
                    if (r_armed) begin
                        n_elapsed = elapsed_inc;
                        if (elapsed_inc >= i_cfg.timeout_ms) begin
                            n_armed           = 1'b0;
                            n_phase           = PH_SYNC1;
                            n_left            = '0;
                            o_res.has_result  = 1'b1;
                            o_res.item.status = ST_TIMEOUT;
                            o_res.item.last   = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

[rtl/core/ubx_response_frame_receiver.sv]
// UBX response frame receiver. Write class, id, payload limit and timeout through the
// config port while idle, then send a start beat followed by received bytes and 1 ms
// ticks. The block finds one frame with the wanted class and id and returns its payload
// one beat per byte (last beat carries the length), a single empty-frame beat, or a
// timeout beat. It takes one input beat every cycle; a result passes through the input
// register, loaded at acceptance, and then the result register, loaded when the held beat
// is processed, and input ready drops only while both registers hold a beat and the
// result is not being taken.
module ubx_response_frame_receiver
    import ubxfr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ubxfr_in_if.sink              i_in,
    ubxfr_out_if.source           o_out
);

    t_cfg      r_cfg;
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      fire;
    t_step_res step_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.want_class    <= RST_WANT_CLASS;
            r_cfg.want_id       <= RST_WANT_ID;
            r_cfg.payload_limit <= RST_PAYLOAD_LIMIT;
            r_cfg.timeout_ms    <= RST_TIMEOUT_MS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WANT_CLASS:    r_cfg.want_class    <= i_cfg_data[7:0];
                CFG_WANT_ID:       r_cfg.want_id       <= i_cfg_data[7:0];
                CFG_PAYLOAD_LIMIT: r_cfg.payload_limit <= i_cfg_data;
                CFG_TIMEOUT_MS:    r_cfg.timeout_ms    <= i_cfg_data;
            endcase
        end
    end

    // process the held beat when the result register is free or draining
    assign fire       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.opcode  <= i_in.opcode;
            r_in.rx_byte <= i_in.rx_byte;
        end
    end

    ubxfr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= step_res.has_result;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && step_res.has_result) begin
            r_out <= step_res.item;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out.status;
    assign o_out.payload_byte = r_out.payload_byte;
    assign o_out.last         = r_out.last;
    assign o_out.length       = r_out.length;

endmodule

[rtl/core/ubxfr_checker.sv]
module ubxfr_checker
    import ubxfr_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    ubxfr_in_if.sink    i_in,
    ubxfr_out_if.source o_out
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.status)
            && $stable(o_out.payload_byte) && $stable(o_out.last) && $stable(o_out.length))
        else $error("result beat changed while stalled");

    // with the result register empty the input side never stalls
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input stalled with no result pending");

    a_mid_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.last |-> o_out.status == ST_PAYLOAD && o_out.length == 16'd0)
        else $error("non-final beat is not a plain payload byte");

    a_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status == ST_TIMEOUT |->
            o_out.last && o_out.length == 16'd0 && o_out.payload_byte == 8'd0)
        else $error("malformed timeout beat");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status == ST_EMPTY |->
            o_out.last && o_out.length == 16'd0 && o_out.payload_byte == 8'd0)
        else $error("malformed empty-frame beat");

endmodule

bind ubx_response_frame_receiver ubxfr_checker u_ubxfr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .o_out   (o_out)
);
